### rtl/mpd_pkg.sv
// ----------------------------------------------------------------------------
// mpd_pkg: shared types and constants of the mouse packet decoder
// Byte positions, flag bits, register indexes, limits and the status struct.
// ----------------------------------------------------------------------------
package mpd_pkg;

    // Bound register width and reset values
    localparam int BOUND_W = 12;
    localparam logic [BOUND_W-1:0] WIDTH_RESET  = 12'd1024;
    localparam logic [BOUND_W-1:0] HEIGHT_RESET = 12'd768;
    localparam logic [BOUND_W-1:0] BOUND_MARGIN = 12'd2;

    // Configuration register indexes
    localparam int CFG_INDEX_W = 1;
    localparam logic [CFG_INDEX_W-1:0] REG_SCREEN_WIDTH  = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_SCREEN_HEIGHT = 1'b1;

    // Item kinds on the input tuser
    localparam logic KIND_BYTE  = 1'b0;
    localparam logic KIND_FRAME = 1'b1;

    // Position of the next byte within a packet
    localparam logic [1:0] IDX_FLAGS = 2'd0;
    localparam logic [1:0] IDX_DX    = 2'd1;
    localparam logic [1:0] IDX_DY    = 2'd2;

    // Bits of the flags byte
    localparam int FLAG_LEFT  = 0;
    localparam int FLAG_RIGHT = 1;
    localparam int FLAG_SYNC  = 3;
    localparam int FLAG_X_OVF = 6;
    localparam int FLAG_Y_OVF = 7;

    // Delta limits
    localparam int DELTA_W = 7;
    localparam logic signed [DELTA_W-1:0] DELTA_LIMIT = 7'sd40;
    localparam logic signed [DELTA_W-1:0] DELTA_FLOOR = -7'sd40;

    // Button and event status of one result
    typedef struct packed {
        logic packet_done;
        logic left_released;
        logic left_pressed;
        logic right_button;
        logic left_button;
    } t_status;

    localparam int STATUS_W = $bits(t_status);

    // Take a raw delta byte as two's complement and clamp it to the limits
    function automatic logic signed [DELTA_W-1:0] clamp_delta(input logic [7:0] raw);
        logic signed [7:0] v;
        logic signed [DELTA_W-1:0] res;
        v = signed'(raw);
        if (v > DELTA_LIMIT) begin
            res = DELTA_LIMIT;
        end else if (v < DELTA_FLOOR) begin
            res = DELTA_FLOOR;
        end else begin
            res = v[DELTA_W-1:0];
        end
        return res;
    endfunction

endpackage

### rtl/mouse_packet_decoder.sv
// ----------------------------------------------------------------------------
// mouse_packet_decoder: PS/2 mouse packet decoder with pointer tracking
// Assembles three-byte mouse packets, moves a clamped pointer and reports
// button levels and per-frame press and release events.
// ----------------------------------------------------------------------------
// Every accepted item, a mouse byte or a frame event, gives exactly one result
// through the registered output buffer. The block takes one item per cycle
// while o_s_tready is high; the state update is a single pass of clamp and add
// logic. A two-entry output buffer (result register plus skid register) lets an
// item be accepted while a finished result is still waiting, so s_tready only
// drops after the downstream side has stalled for two results. Bounds may be
// rewritten at any idle time and apply from the next completed packet; the
// pointer is not moved by a write.
module mouse_packet_decoder #(
    parameter int COORD_WIDTH = 12
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Input stream
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    input  logic [7:0]                        i_s_tdata,   // [7:0] rx_byte
    input  logic                              i_s_tuser,   // [0] kind
    // Result stream
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    // pos_x, pos_y, left_button, right_button, left_pressed, left_released,
    // packet_done, zero fill
    output logic [((2*COORD_WIDTH+mpd_pkg::STATUS_W+7)/8)*8-1:0] o_m_tdata,
    // Configuration writes
    input  logic                              i_cfg_we,
    input  logic [mpd_pkg::CFG_INDEX_W-1:0]   i_cfg_index,
    input  logic [mpd_pkg::BOUND_W-1:0]       i_cfg_data
);
    import mpd_pkg::*;

    localparam int PAYLOAD_W = 2 * COORD_WIDTH + STATUS_W;
    localparam int TDATA_W   = ((PAYLOAD_W + 7) / 8) * 8;

    logic [BOUND_W-1:0]     r_screen_width;
    logic [BOUND_W-1:0]     r_screen_height;
    logic                   w_in_xfer;
    logic                   w_out_xfer;
    logic [COORD_WIDTH-1:0] w_pos_x;
    logic [COORD_WIDTH-1:0] w_pos_y;
    t_status                w_status;
    logic [PAYLOAD_W-1:0]   w_payload;
    logic [PAYLOAD_W-1:0]   r_out_data;
    logic [PAYLOAD_W-1:0]   r_skid_data;
    logic                   r_out_valid;
    logic                   r_skid_valid;

    // Bound registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_screen_width  <= WIDTH_RESET;
            r_screen_height <= HEIGHT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_SCREEN_WIDTH:  r_screen_width  <= i_cfg_data;
                REG_SCREEN_HEIGHT: r_screen_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_s_tready = !r_skid_valid;
    assign w_in_xfer  = i_s_tvalid && o_s_tready;
    assign w_out_xfer = r_out_valid && i_m_tready;

    mpd_core #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_in_xfer),
        .i_kind   (i_s_tuser),
        .i_byte   (i_s_tdata),
        .i_width  (r_screen_width),
        .i_height (r_screen_height),
        .o_pos_x  (w_pos_x),
        .o_pos_y  (w_pos_y),
        .o_status (w_status)
    );

    assign w_payload = {w_status, w_pos_y, w_pos_x};

    // Output buffer: load the result register, spill to skid when it is held
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (w_out_xfer) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end
        end else if (w_in_xfer) begin
            if (!r_out_valid || w_out_xfer) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (w_out_xfer) begin
            r_out_valid <= 1'b0;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (w_out_xfer) begin
                r_out_data <= r_skid_data;
            end
        end else if (w_in_xfer) begin
            if (!r_out_valid || w_out_xfer) begin
                r_out_data <= w_payload;
            end else begin
                r_skid_data <= w_payload;
            end
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = TDATA_W'(r_out_data);

endmodule

### rtl/mpd_core.sv
// ----------------------------------------------------------------------------
// mpd_core: packet assembly, pointer tracking and button event state
// Updates the decoder state on each transfer and presents the result of it.
// ----------------------------------------------------------------------------
module mpd_core #(
    parameter int COORD_WIDTH = 12
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    input  logic                         i_kind,
    input  logic [7:0]                   i_byte,
    input  logic [mpd_pkg::BOUND_W-1:0]  i_width,
    input  logic [mpd_pkg::BOUND_W-1:0]  i_height,
    output logic [COORD_WIDTH-1:0]       o_pos_x,
    output logic [COORD_WIDTH-1:0]       o_pos_y,
    output mpd_pkg::t_status             o_status
);
    import mpd_pkg::*;

    localparam int SUM_W = COORD_WIDTH + 2;
    localparam int CMP_W = ((COORD_WIDTH > BOUND_W) ? COORD_WIDTH : BOUND_W) + 2;
    localparam logic [COORD_WIDTH-1:0] X_RESET = COORD_WIDTH'(120);
    localparam logic [COORD_WIDTH-1:0] Y_RESET = COORD_WIDTH'(90);

    // Clamp a moved coordinate to 0..bound-2 (limit 0 for bounds below two)
    function automatic logic [COORD_WIDTH-1:0] fit_coord(
        input logic signed [SUM_W-1:0]   v,
        input logic [BOUND_W-1:0]        bound
    );
        logic [BOUND_W-1:0]      lim;
        logic signed [CMP_W-1:0] v_w;
        logic signed [CMP_W-1:0] lim_w;
        logic signed [CMP_W-1:0] res;
        lim   = (bound < BOUND_MARGIN) ? '0 : bound - BOUND_MARGIN;
        v_w   = CMP_W'(v);
        lim_w = signed'(CMP_W'(lim));
        if (v_w < 0) begin
            res = '0;
        end else if (v_w > lim_w) begin
            res = lim_w;
        end else begin
            res = v_w;
        end
        return res[COORD_WIDTH-1:0];
    endfunction

    logic [1:0]             r_byte_index, n_byte_index;
    logic [7:0]             r_first_byte, n_first_byte;
    logic [7:0]             r_second_byte, n_second_byte;
    logic [COORD_WIDTH-1:0] r_cursor_x, n_cursor_x;
    logic [COORD_WIDTH-1:0] r_cursor_y, n_cursor_y;
    logic                   r_left_level, n_left_level;
    logic                   r_right_level, n_right_level;
    logic [7:0]             r_press_count, n_press_count;
    logic [7:0]             r_release_count, n_release_count;
    logic                   r_left_at_frame, n_left_at_frame;
    logic                   r_pressed_flag, n_pressed_flag;
    logic                   r_released_flag, n_released_flag;
    logic                   w_done;

    logic signed [DELTA_W-1:0] w_dx;
    logic signed [DELTA_W-1:0] w_dy;
    logic signed [SUM_W-1:0]   w_sum_x;
    logic signed [SUM_W-1:0]   w_sum_y;
    logic                      w_left;

    // Deltas of a completing packet, zeroed on overflow
    assign w_dx = r_first_byte[FLAG_X_OVF] ? '0 : clamp_delta(r_second_byte);
    assign w_dy = r_first_byte[FLAG_Y_OVF] ? '0 : clamp_delta(i_byte);
    assign w_sum_x = signed'({2'b00, r_cursor_x}) + SUM_W'(w_dx);
    assign w_sum_y = signed'({2'b00, r_cursor_y}) - SUM_W'(w_dy);
    assign w_left  = r_first_byte[FLAG_LEFT];

    // Next state for the item in transfer
    always_comb begin
        n_byte_index    = r_byte_index;
        n_first_byte    = r_first_byte;
        n_second_byte   = r_second_byte;
        n_cursor_x      = r_cursor_x;
        n_cursor_y      = r_cursor_y;
        n_left_level    = r_left_level;
        n_right_level   = r_right_level;
        n_press_count   = r_press_count;
        n_release_count = r_release_count;
        n_left_at_frame = r_left_at_frame;
        n_pressed_flag  = r_pressed_flag;
        n_released_flag = r_released_flag;
        w_done          = 1'b0;
        if (i_kind == KIND_FRAME) begin
            // Turn counts and level change into flags, then restart counting
            n_pressed_flag  = (r_press_count != '0) || (r_left_level && !r_left_at_frame);
            n_released_flag = (r_release_count != '0) || (!r_left_level && r_left_at_frame);
            n_left_at_frame = r_left_level;
            n_press_count   = '0;
            n_release_count = '0;
        end else begin
            case (r_byte_index)
                IDX_FLAGS: begin
                    // Drop a first byte without the sync bit
                    if (i_byte[FLAG_SYNC]) begin
                        n_first_byte = i_byte;
                        n_byte_index = IDX_DX;
                    end
                end
                IDX_DX: begin
                    n_second_byte = i_byte;
                    n_byte_index  = IDX_DY;
                end
                default: begin
                    // Complete the packet: move, clamp, track buttons
                    n_byte_index  = IDX_FLAGS;
                    w_done        = 1'b1;
                    n_cursor_x    = fit_coord(w_sum_x, i_width);
                    n_cursor_y    = fit_coord(w_sum_y, i_height);
                    if (w_left && !r_left_level) begin
                        n_press_count = r_press_count + 8'd1;
                    end
                    if (!w_left && r_left_level) begin
                        n_release_count = r_release_count + 8'd1;
                    end
                    n_left_level  = w_left;
                    n_right_level = r_first_byte[FLAG_RIGHT];
                end
            endcase
        end
    end

    // Advance the state on a transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_index    <= IDX_FLAGS;
            r_first_byte    <= '0;
            r_second_byte   <= '0;
            r_cursor_x      <= X_RESET;
            r_cursor_y      <= Y_RESET;
            r_left_level    <= 1'b0;
            r_right_level   <= 1'b0;
            r_press_count   <= '0;
            r_release_count <= '0;
            r_left_at_frame <= 1'b0;
            r_pressed_flag  <= 1'b0;
            r_released_flag <= 1'b0;
        end else if (i_valid) begin
            r_byte_index    <= n_byte_index;
            r_first_byte    <= n_first_byte;
            r_second_byte   <= n_second_byte;
            r_cursor_x      <= n_cursor_x;
            r_cursor_y      <= n_cursor_y;
            r_left_level    <= n_left_level;
            r_right_level   <= n_right_level;
            r_press_count   <= n_press_count;
            r_release_count <= n_release_count;
            r_left_at_frame <= n_left_at_frame;
            r_pressed_flag  <= n_pressed_flag;
            r_released_flag <= n_released_flag;
        end
    end

    // Result reflects the state after this item
    assign o_pos_x                = n_cursor_x;
    assign o_pos_y                = n_cursor_y;
    assign o_status.left_button   = n_left_level;
    assign o_status.right_button  = n_right_level;
    assign o_status.left_pressed  = n_pressed_flag;
    assign o_status.left_released = n_released_flag;
    assign o_status.packet_done   = w_done;

endmodule

### rtl/mpd_checker.sv
// ----------------------------------------------------------------------------
// mpd_checker: port-level checks of the mouse packet decoder
// Watches the stream ports for buffer and result ordering slips.
// ----------------------------------------------------------------------------
module mpd_checker #(
    parameter int COORD_WIDTH = 12
) (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_s_tvalid,
    input logic                              o_s_tready,
    input logic                              i_s_tuser,
    input logic                              o_m_tvalid,
    input logic                              i_m_tready,
    input logic [((2*COORD_WIDTH+mpd_pkg::STATUS_W+7)/8)*8-1:0] o_m_tdata
);
    import mpd_pkg::*;

    localparam int DONE_BIT = 2 * COORD_WIDTH + STATUS_W - 1;

    // Hold a stalled result
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("stalled result changed");

    // Drop ready only while a result is waiting
    a_ready_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> o_m_tvalid)
        else $error("input stalled with empty output");

    // A frame event taken into an empty output never reports a packet
    a_frame_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready && i_s_tuser && !o_m_tvalid
        |=> o_m_tvalid && !o_m_tdata[DONE_BIT])
        else $error("frame event result missing or marked as packet");

    // Reset empties the output
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid after reset");

endmodule

bind mouse_packet_decoder mpd_checker #(
    .COORD_WIDTH (COORD_WIDTH)
) u_mpd_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .i_s_tuser  (i_s_tuser),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);

### tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the mouse packet decoder
// Drives mouse bytes and frame events over the input stream and predicts every
// result with a local pointer tracker. Directed rows come first, then random
// packets, noise and frames over several screen bounds, with random stalls.
// ----------------------------------------------------------------------------
module tb_top;
    import mpd_pkg::*;

    localparam int COORD_W    = 12;
    localparam int TDATA_W    = ((2*COORD_W + STATUS_W + 7) / 8) * 8;
    localparam int PAD_W      = TDATA_W - 2*COORD_W - STATUS_W;
    localparam int HOME_X     = 120;
    localparam int HOME_Y     = 90;
    localparam int MOVE_LIMIT = 40;
    localparam int BOUND_MIN  = 2;
    localparam int BOUND_MAX  = 4095;
    localparam int HOLD_CYCLES  = 40;
    localparam int QUIET_LIMIT  = 1000;
    localparam int PHASE_ITEMS  = 125;
    localparam int TOGGLE_PACKETS = 64;

    // One result word, laid out as on the result tdata
    typedef struct packed {
        logic [PAD_W-1:0]   fill;
        t_status            status;
        logic [COORD_W-1:0] pos_y;
        logic [COORD_W-1:0] pos_x;
    } pointer_report_t;

    typedef struct {
        logic            kind;
        logic [7:0]      data;
        bit              typed;
        pointer_report_t want;
    } stim_row_t;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_s_tvalid = 1'b0;
    logic               o_s_tready;
    logic [7:0]         i_s_tdata = '0;
    logic               i_s_tuser = KIND_BYTE;
    logic               o_m_tvalid;
    logic               i_m_tready = 1'b0;
    logic [TDATA_W-1:0] o_m_tdata;
    logic               i_cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0] i_cfg_index = REG_SCREEN_WIDTH;
    logic [BOUND_W-1:0] i_cfg_data = '0;

    // Tracker state, mirrors the block after reset
    logic [1:0]         pkt_slot = IDX_FLAGS;
    logic [7:0]         flags_byte = '0;
    logic [7:0]         dx_byte = '0;
    logic [COORD_W-1:0] cur_x = COORD_W'(HOME_X);
    logic [COORD_W-1:0] cur_y = COORD_W'(HOME_Y);
    logic               left_lvl = 1'b0;
    logic               right_lvl = 1'b0;
    logic [7:0]         press_cnt = '0;
    logic [7:0]         release_cnt = '0;
    logic               left_at_frame = 1'b0;
    logic               pressed_flg = 1'b0;
    logic               released_flg = 1'b0;
    logic [BOUND_W-1:0] width_bound = WIDTH_RESET;
    logic [BOUND_W-1:0] height_bound = HEIGHT_RESET;

    pointer_report_t report_q[$];
    stim_row_t       directed_rows[$];
    int              error_count = 0;
    int              items_sent = 0;
    bit              src_gaps_on = 1'b1;
    bit              sink_stalls_on = 1'b1;
    bit              hold_request = 1'b0;
    int              hold_left = 0;
    int              stall_left = 0;
    int              quiet_cycles = 0;

    mouse_packet_decoder #(
        .COORD_WIDTH(COORD_W)
    ) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Take a delta byte as two's complement and limit its magnitude
    function automatic int clip_delta(input logic [7:0] raw);
        int v;
        v = int'($signed(raw));
        if (v > MOVE_LIMIT) v = MOVE_LIMIT;
        if (v < -MOVE_LIMIT) v = -MOVE_LIMIT;
        return v;
    endfunction

    // Hold a coordinate inside 0..bound-2, a tiny bound pins it to 0
    function automatic logic [COORD_W-1:0] fit_coord(input int v,
                                                     input logic [BOUND_W-1:0] bound);
        int top;
        top = int'(bound) - int'(BOUND_MARGIN);
        if (top < 0) top = 0;
        if (v < 0) v = 0;
        if (v > top) v = top;
        return COORD_W'(v);
    endfunction

    // Advance the tracker by one item and return the report it gives
    function automatic pointer_report_t decode_item(input logic kind, input logic [7:0] data);
        pointer_report_t r;
        int dx;
        int dy;
        r = '0;
        if (kind == KIND_FRAME) begin
            pressed_flg   = (press_cnt != 0) || (left_lvl && !left_at_frame);
            released_flg  = (release_cnt != 0) || (!left_lvl && left_at_frame);
            left_at_frame = left_lvl;
            press_cnt     = '0;
            release_cnt   = '0;
        end else begin
            case (pkt_slot)
                IDX_FLAGS: begin
                    // drop bytes without the sync bit to find the packet start
                    if (data[FLAG_SYNC]) begin
                        flags_byte = data;
                        pkt_slot   = IDX_DX;
                    end
                end
                IDX_DX: begin
                    dx_byte  = data;
                    pkt_slot = IDX_DY;
                end
                default: begin
                    dx = flags_byte[FLAG_X_OVF] ? 0 : clip_delta(dx_byte);
                    dy = flags_byte[FLAG_Y_OVF] ? 0 : clip_delta(data);
                    cur_x = fit_coord(int'(cur_x) + dx, width_bound);
                    cur_y = fit_coord(int'(cur_y) - dy, height_bound);
                    if (flags_byte[FLAG_LEFT] && !left_lvl) press_cnt = press_cnt + 8'd1;
                    if (!flags_byte[FLAG_LEFT] && left_lvl) release_cnt = release_cnt + 8'd1;
                    left_lvl  = flags_byte[FLAG_LEFT];
                    right_lvl = flags_byte[FLAG_RIGHT];
                    pkt_slot  = IDX_FLAGS;
                    r.status.packet_done = 1'b1;
                end
            endcase
        end
        r.pos_x = cur_x;
        r.pos_y = cur_y;
        r.status.left_button   = left_lvl;
        r.status.right_button  = right_lvl;
        r.status.left_pressed  = pressed_flg;
        r.status.left_released = released_flg;
        return r;
    endfunction

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            $display("%0t: %s expected %0d got %0d", $time, name, want, got);
            error_count++;
        end
    endfunction

    // Compare one result transfer with the oldest pending report
    function automatic void check_result(input logic [TDATA_W-1:0] word);
        pointer_report_t got;
        pointer_report_t want;
        got = word;
        if (report_q.size() == 0) begin
            $display("%0t: result %h expected nothing got a transfer", $time, word);
            error_count++;
            return;
        end
        want = report_q.pop_front();
        check_field("pos_x", want.pos_x, got.pos_x);
        check_field("pos_y", want.pos_y, got.pos_y);
        check_field("left_button", want.status.left_button, got.status.left_button);
        check_field("right_button", want.status.right_button, got.status.right_button);
        check_field("left_pressed", want.status.left_pressed, got.status.left_pressed);
        check_field("left_released", want.status.left_released, got.status.left_released);
        check_field("packet_done", want.status.packet_done, got.status.packet_done);
        check_field("fill", want.fill, got.fill);
    endfunction

    function automatic void add_checked(input logic kind, input logic [7:0] data,
                                        input int x, input int y, input bit lb,
                                        input bit rb, input bit lp, input bit lr,
                                        input bit dn);
        stim_row_t row;
        row.kind  = kind;
        row.data  = data;
        row.typed = 1'b1;
        row.want  = '0;
        row.want.pos_x = COORD_W'(x);
        row.want.pos_y = COORD_W'(y);
        row.want.status.left_button   = lb;
        row.want.status.right_button  = rb;
        row.want.status.left_pressed  = lp;
        row.want.status.left_released = lr;
        row.want.status.packet_done   = dn;
        directed_rows.push_back(row);
    endfunction

    function automatic void add_free(input logic kind, input logic [7:0] data);
        stim_row_t row;
        row.kind  = kind;
        row.data  = data;
        row.typed = 1'b0;
        row.want  = '0;
        directed_rows.push_back(row);
    endfunction

    function automatic logic [7:0] random_flags();
        logic [7:0] f;
        f = 8'($urandom_range(0, 255));
        f[FLAG_SYNC] = 1'b1;
        if ($urandom_range(0, 3) != 0) begin
            f[FLAG_X_OVF] = 1'b0;
            f[FLAG_Y_OVF] = 1'b0;
        end
        return f;
    endfunction

    // Mostly drift in one direction so the pointer reaches the edges
    function automatic logic [7:0] rand_delta(input int drift);
        case ($urandom_range(0, 3))
            0:       return 8'($urandom_range(0, 255));
            1, 2:    return 8'(drift * int'($urandom_range(0, 48)));
            default: return 8'(int'($urandom_range(0, 6)) - 3);
        endcase
    endfunction

    // Offer one item, predict it on transfer, then maybe leave a gap
    task automatic push_item(input stim_row_t row);
        pointer_report_t pred;
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= row.kind;
        i_s_tdata  <= row.data;
        do @(posedge i_clk); while (!o_s_tready);
        pred = decode_item(row.kind, row.data);
        report_q.push_back(row.typed ? row.want : pred);
        items_sent++;
        if (src_gaps_on && $urandom_range(0, 3) == 0) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
    endtask

    task automatic send(input logic kind, input logic [7:0] data);
        stim_row_t row;
        row.kind  = kind;
        row.data  = data;
        row.typed = 1'b0;
        row.want  = '0;
        push_item(row);
    endtask

    task automatic send_packet(input logic [7:0] flags, input logic [7:0] dx,
                               input logic [7:0] dy);
        send(KIND_BYTE, flags);
        send(KIND_BYTE, dx);
        send(KIND_BYTE, dy);
    endtask

    // Stop offering and wait until every pending report has been checked
    task automatic drain();
        i_s_tvalid <= 1'b0;
        while (report_q.size() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic set_bounds(input logic [BOUND_W-1:0] w, input logic [BOUND_W-1:0] h);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= REG_SCREEN_WIDTH;
        i_cfg_data  <= w;
        @(posedge i_clk);
        i_cfg_index <= REG_SCREEN_HEIGHT;
        i_cfg_data  <= h;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        width_bound  = w;
        height_bound = h;
    endtask

    // Mostly well-formed packets, plus frames, stray bytes and cut packets
    task automatic random_run(input int count, input int dx_drift, input int dy_drift);
        int start;
        int pick;
        logic [7:0] f;
        start = items_sent;
        while (items_sent - start < count) begin
            pick = $urandom_range(0, 99);
            f = random_flags();
            if (pick < 70) begin
                send_packet(f, rand_delta(dx_drift), rand_delta(dy_drift));
            end else if (pick < 82) begin
                send(KIND_FRAME, 8'($urandom_range(0, 255)));
            end else if (pick < 92) begin
                send(KIND_BYTE, 8'($urandom_range(0, 255)));
            end else if (pick < 96) begin
                send(KIND_BYTE, f);
                if ($urandom_range(0, 1) != 0) send(KIND_BYTE, rand_delta(dx_drift));
            end else begin
                send(KIND_BYTE, f);
                send(KIND_FRAME, 8'($urandom_range(0, 255)));
                send(KIND_BYTE, rand_delta(dx_drift));
                send(KIND_BYTE, rand_delta(dy_drift));
            end
        end
    endtask

    // Toggle left many times within one frame period so both edge counters climb
    task automatic toggle_run();
        logic [7:0] f;
        while (pkt_slot != IDX_FLAGS) send(KIND_BYTE, 8'($urandom_range(0, 255)));
        f = random_flags();
        f[FLAG_LEFT] = 1'b0;
        send_packet(f, rand_delta(1), rand_delta(-1));
        send(KIND_FRAME, 8'($urandom_range(0, 255)));
        for (int i = 0; i < TOGGLE_PACKETS; i++) begin
            f = random_flags();
            f[FLAG_LEFT] = (i % 2 == 0);
            send_packet(f, rand_delta(1), rand_delta(-1));
        end
        send(KIND_FRAME, 8'($urandom_range(0, 255)));
    endtask

    // Result side: check transfers, then pick the next tready
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) check_result(o_m_tdata);
        if (hold_request) begin
            hold_left    = HOLD_CYCLES;
            hold_request = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_m_tready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            i_m_tready <= 1'b0;
        end else if (sink_stalls_on && $urandom_range(0, 4) == 0) begin
            stall_left = $urandom_range(1, 7) - 1;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= 1'b1;
        end
    end

    // End the run when no transfer happens for too long
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
            $display("FAIL mouse_packet_decoder");
            $finish;
        end
    end

    initial begin
        // Sync drops, frames mid-packet, delta clamps, press then release
        add_checked(KIND_FRAME, 8'hFF, HOME_X, HOME_Y, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
        add_checked(KIND_BYTE, 8'h00, HOME_X, HOME_Y, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
        add_checked(KIND_BYTE, 8'hF7, HOME_X, HOME_Y, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
        add_checked(KIND_BYTE, 8'h09, HOME_X, HOME_Y, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
        add_checked(KIND_BYTE, 8'h7F, HOME_X, HOME_Y, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
        add_checked(KIND_FRAME, 8'hAA, HOME_X, HOME_Y, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
        add_checked(KIND_BYTE, 8'h80, 160, 130, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1);
        add_checked(KIND_FRAME, 8'h00, 160, 130, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0);
        // Both overflow bits zero the deltas; left is released
        add_checked(KIND_BYTE, 8'hC8, 160, 130, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0);
        add_checked(KIND_BYTE, 8'h7F, 160, 130, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0);
        add_checked(KIND_BYTE, 8'h7F, 160, 130, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1);
        add_checked(KIND_FRAME, 8'h55, 160, 130, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0);
        add_free(KIND_BYTE, 8'h0A);
        add_free(KIND_BYTE, 8'h28);
        add_free(KIND_BYTE, 8'h28);
        add_free(KIND_BYTE, 8'h3B);
        add_free(KIND_BYTE, 8'hD8);
        add_free(KIND_BYTE, 8'h29);
        add_free(KIND_BYTE, 8'h18);
        add_free(KIND_BYTE, 8'h81);
        add_free(KIND_BYTE, 8'h7F);
        add_free(KIND_FRAME, 8'h00);
        add_free(KIND_BYTE, 8'hFF);
        add_free(KIND_BYTE, 8'h00);
        add_free(KIND_BYTE, 8'hFF);
        add_free(KIND_FRAME, 8'hFF);

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[i]) push_item(directed_rows[i]);

        // Random phases, each with its own bounds, drift and idling
        for (int phase = 0; phase < 8; phase++) begin
            drain();
            case (phase)
                0:       set_bounds(BOUND_W'(BOUND_MAX), BOUND_W'(BOUND_MAX));
                1:       set_bounds(BOUND_W'(BOUND_MIN), BOUND_W'(BOUND_MIN));
                2:       set_bounds(BOUND_W'(BOUND_MIN + 1), BOUND_W'(BOUND_MAX));
                3:       set_bounds(BOUND_W'(BOUND_MAX), BOUND_W'(BOUND_MIN));
                5:       set_bounds(WIDTH_RESET, HEIGHT_RESET);
                6:       set_bounds(BOUND_W'($urandom_range(BOUND_MIN, BOUND_MAX)),
                                    BOUND_W'($urandom_range(BOUND_MIN, BOUND_MAX)));
                default: set_bounds(BOUND_W'($urandom_range(BOUND_MIN, 300)),
                                    BOUND_W'($urandom_range(BOUND_MIN, 300)));
            endcase
            src_gaps_on    = (phase != 7) && ($urandom_range(0, 2) != 0);
            sink_stalls_on = (phase != 7) && ($urandom_range(0, 2) != 0);
            if (phase == 2) begin
                // keep offering while the result side holds off
                src_gaps_on  = 1'b0;
                hold_request = 1'b1;
            end
            if (phase == 4) begin
                toggle_run();
            end else begin
                random_run(PHASE_ITEMS, $urandom_range(0, 1) ? 1 : -1,
                           $urandom_range(0, 1) ? 1 : -1);
            end
        end

        drain();
        repeat (4) @(posedge i_clk);
        if (error_count == 0) begin
            $display("PASS mouse_packet_decoder");
        end else begin
            $display("FAIL mouse_packet_decoder");
        end
        $finish;
    end

endmodule
